@@ hdl/sic_pkg.sv @@
// sic_pkg: shared types and codes for the scanline interrupt controller
// item kinds, bus register offsets, configuration indexes, beat structs
// no dependencies
package sic_pkg;

    localparam int LINE_W      = 9;
    localparam int BYTE_W      = 8;
    localparam int MODE_W      = 3;
    localparam int ADDR_W      = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_BUS_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BUS_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GUN_TRIG  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GUN_ACK   = 3'd4;

    // bus register offsets
    localparam logic [ADDR_W-1:0] REG_CTRL    = 2'd0;
    localparam logic [ADDR_W-1:0] REG_COMPARE = 2'd1;
    localparam logic [ADDR_W-1:0] REG_ACK     = 2'd2;
    localparam logic [ADDR_W-1:0] REG_STATUS  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VISIBLE_TOP    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VISIBLE_BOTTOM = 1'd1;

    localparam logic [LINE_W-1:0] VISIBLE_TOP_RESET    = 9'd0;
    localparam logic [LINE_W-1:0] VISIBLE_BOTTOM_RESET = 9'd239;
    localparam logic [BYTE_W-1:0] READ_ACK_VALUE       = 8'hff;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] reg_addr;
        logic [BYTE_W-1:0] write_data;
        logic [LINE_W-1:0] current_line;
        logic              vblank_level;
        logic              hblank_level;
        logic [LINE_W-1:0] gun_y;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              raster_a_irq;
        logic              raster_b_irq;
        logic              vblank_irq;
        logic              gun_irq;
    } result_t;

endpackage

@@ hdl/sic_in_stage.sv @@
// sic_in_stage: input register of the controller
// holds one accepted beat until the core takes it; uses sic_pkg
module sic_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sic_pkg::item_t item_in,
    input  logic           downstream_ready,
    output logic           fire,
    output sic_pkg::item_t item_out
);

    logic           valid_reg;
    logic           valid_next;
    sic_pkg::item_t item_reg;

    assign fire     = valid_reg && downstream_ready;
    assign in_ready = !valid_reg || downstream_ready;
    assign item_out = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

@@ hdl/sic_core.sv @@
// sic_core: controller state, configuration registers and per-item update
// one item is applied per fire strobe; uses sic_pkg
module sic_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [sic_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sic_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             fire,
    input  sic_pkg::item_t                   item,
    output sic_pkg::result_t                 result
);

    logic [sic_pkg::LINE_W-1:0] top_reg;
    logic [sic_pkg::LINE_W-1:0] bottom_reg;

    logic                       target_reg, target_next;
    logic                       masked_reg, masked_next;
    logic [sic_pkg::BYTE_W-1:0] compare_reg, compare_next;
    logic [sic_pkg::BYTE_W-1:0] latch_reg, latch_next;
    logic                       r1_reg, r1_next;
    logic                       r2_reg, r2_next;
    logic                       vbl_reg, vbl_next;
    logic                       gun_reg, gun_next;
    logic [sic_pkg::BYTE_W-1:0] rd;

    logic [sic_pkg::LINE_W-1:0] compare_ext;
    logic [sic_pkg::LINE_W-1:0] latch_ext;
    logic                       compare_visible;
    logic                       latch_visible;
    logic [sic_pkg::LINE_W:0]   vblank_start;

    assign compare_ext     = {1'b0, compare_reg};
    assign latch_ext       = {1'b0, latch_reg};
    assign compare_visible = (compare_ext >= top_reg) && (compare_ext <= bottom_reg);
    assign latch_visible   = (latch_ext >= top_reg) && (latch_ext <= bottom_reg);
    // bottom of 511 gives 512, which a 9-bit line never reaches
    assign vblank_start    = {1'b0, bottom_reg} + {{sic_pkg::LINE_W{1'b0}}, 1'b1};

    always_comb
    begin
        target_next  = target_reg;
        masked_next  = masked_reg;
        compare_next = compare_reg;
        latch_next   = latch_reg;
        r1_next      = r1_reg;
        r2_next      = r2_reg;
        vbl_next     = vbl_reg;
        gun_next     = gun_reg;
        rd           = '0;
        case (item.mode)
            sic_pkg::MODE_BUS_WRITE:
            begin
                case (item.reg_addr)
                    sic_pkg::REG_CTRL:
                    begin
                        target_next = item.write_data[4];
                        masked_next = item.write_data[1];
                        if (item.write_data[1])
                        begin
                            r1_next = 1'b0;
                            r2_next = 1'b0;
                        end
                    end
                    sic_pkg::REG_COMPARE: compare_next = item.write_data;
                    sic_pkg::REG_ACK:     vbl_next     = 1'b0;
                    default:              ;
                endcase
            end
            sic_pkg::MODE_BUS_READ:
            begin
                case (item.reg_addr)
                    sic_pkg::REG_COMPARE: rd = compare_reg;
                    sic_pkg::REG_ACK:
                    begin
                        r1_next = 1'b0;
                        r2_next = 1'b0;
                        rd      = sic_pkg::READ_ACK_VALUE;
                    end
                    sic_pkg::REG_STATUS:
                    begin
                        rd = {1'b1, gun_reg, r1_reg | r2_reg, vbl_reg, 2'b00,
                              item.vblank_level, item.hblank_level};
                    end
                    default:              ;
                endcase
            end
            sic_pkg::MODE_TICK:
            begin
                if (compare_visible && (item.current_line == compare_ext) && !masked_reg)
                begin
                    if (target_reg)
                    begin
                        r2_next = 1'b1;
                    end
                    else
                    begin
                        r1_next = 1'b1;
                    end
                end
                if (latch_visible && (item.current_line == latch_ext))
                begin
                    gun_next = 1'b1;
                end
                if ({1'b0, item.current_line} == vblank_start)
                begin
                    vbl_next = 1'b1;
                end
            end
            sic_pkg::MODE_GUN_TRIG: latch_next = item.gun_y[sic_pkg::LINE_W-1:1];
            sic_pkg::MODE_GUN_ACK:  gun_next   = 1'b0;
            default:                ;
        endcase
    end

    assign result.read_data    = rd;
    assign result.raster_a_irq = r1_next;
    assign result.raster_b_irq = r2_next;
    assign result.vblank_irq   = vbl_next;
    assign result.gun_irq      = gun_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= sic_pkg::VISIBLE_TOP_RESET;
            bottom_reg <= sic_pkg::VISIBLE_BOTTOM_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                sic_pkg::CFG_VISIBLE_TOP:    top_reg    <= cfg_data;
                sic_pkg::CFG_VISIBLE_BOTTOM: bottom_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= 1'b0;
            masked_reg  <= 1'b1;
            compare_reg <= '0;
            latch_reg   <= '0;
            r1_reg      <= 1'b0;
            r2_reg      <= 1'b0;
            vbl_reg     <= 1'b0;
            gun_reg     <= 1'b0;
        end
        else if (fire)
        begin
            target_reg  <= target_next;
            masked_reg  <= masked_next;
            compare_reg <= compare_next;
            latch_reg   <= latch_next;
            r1_reg      <= r1_next;
            r2_reg      <= r2_next;
            vbl_reg     <= vbl_next;
            gun_reg     <= gun_next;
        end
    end

    // a masked raster never holds a pending flag
    a_mask_clears: assert property (@(posedge clk) disable iff (!rst_n)
        masked_reg |-> !(r1_reg || r2_reg))
        else $error("raster flag pending while masked");

    // gun flag rises only on a tick
    a_gun_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(gun_reg) |-> $past(fire && (item.mode == sic_pkg::MODE_TICK)))
        else $error("gun flag set outside a tick");

    // raster flags rise only on a tick
    a_raster_rise: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(r1_reg) || $rose(r2_reg)) |-> $past(fire && (item.mode == sic_pkg::MODE_TICK)))
        else $error("raster flag set outside a tick");

endmodule

@@ hdl/sic_out_stage.sv @@
// sic_out_stage: result register of the controller
// holds a finished beat until it is taken; uses sic_pkg
module sic_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sic_pkg::result_t result_in,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output sic_pkg::result_t result_out
);

    logic             valid_reg;
    logic             valid_next;
    sic_pkg::result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

@@ hdl/scanline_irq_controller.sv @@
// scanline_irq_controller: top level of the video interrupt controller
// instantiates sic_in_stage, sic_core and sic_out_stage; uses sic_pkg
//
// One beat in, one beat out, at a sustained rate of one item per clock
// while out_ready stays high. An accepted item sits in the input register,
// is applied to the controller state by one pass of logic in the core when
// the output register can load, and its result lands in the output
// register, whose out_valid stays high until the result is taken.
// The two registers soak up a stall on the result side, so in_ready drops
// only when both hold a beat and out_ready is low.
// Item kinds: bus write, bus read, scanline tick, lightgun trigger and
// lightgun acknowledge; the result carries the read byte (zero unless a
// bus read) and the four interrupt line levels after the item.
// The user must write configuration (visible_top, visible_bottom) through
// cfg_write_en/cfg_index/cfg_data while the block is idle; nothing enforces it.
module scanline_irq_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write_en,
    input  logic [sic_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sic_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input beat
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sic_pkg::MODE_W-1:0]       mode,
    input  logic [sic_pkg::ADDR_W-1:0]       reg_addr,
    input  logic [sic_pkg::BYTE_W-1:0]       write_data,
    input  logic [sic_pkg::LINE_W-1:0]       current_line,
    input  logic                             vblank_level,
    input  logic                             hblank_level,
    input  logic [sic_pkg::LINE_W-1:0]       gun_y,
    // result beat
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sic_pkg::BYTE_W-1:0]       read_data,
    output logic                             raster_a_irq,
    output logic                             raster_b_irq,
    output logic                             vblank_irq,
    output logic                             gun_irq
);

    sic_pkg::item_t   item_in;
    sic_pkg::item_t   item_held;
    sic_pkg::result_t result_comb;
    sic_pkg::result_t result_held;
    logic             fire;
    logic             can_load;

    // gather the input fields into one beat
    assign item_in.mode         = mode;
    assign item_in.reg_addr     = reg_addr;
    assign item_in.write_data   = write_data;
    assign item_in.current_line = current_line;
    assign item_in.vblank_level = vblank_level;
    assign item_in.hblank_level = hblank_level;
    assign item_in.gun_y        = gun_y;

    // input register
    sic_in_stage u_in_stage (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .item_in          (item_in),
        .downstream_ready (can_load),
        .fire             (fire),
        .item_out         (item_held)
    );

    // state update and result for the held item
    sic_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fire         (fire),
        .item         (item_held),
        .result       (result_comb)
    );

    // result register
    sic_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result_in  (result_comb),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_held)
    );

    // spread the result beat onto its ports
    assign read_data    = result_held.read_data;
    assign raster_a_irq = result_held.raster_a_irq;
    assign raster_b_irq = result_held.raster_b_irq;
    assign vblank_irq   = result_held.vblank_irq;
    assign gun_irq      = result_held.gun_irq;

endmodule

@@ bench/scanline_irq_controller_tb.sv @@
// scanline_irq_controller_tb: self-checking bench for the video interrupt controller
// a queue-fed driver, a clocked monitor and a behavioural predictor of the register state
// depends on sic_pkg and scanline_irq_controller
module scanline_irq_controller_tb;

    import sic_pkg::*;

    // item kinds that the block must ignore
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int CHUNK_ITEMS  = 112;
    localparam int CHUNKS       = 3;
    localparam int REPORT_LIMIT = 10;

    // visible window settings swept across the random part; extremes included,
    // plus an empty window (top above bottom) and a bottom that never starts vblank
    localparam int N_WINDOWS = 6;
    localparam logic [LINE_W-1:0] WIN_TOP [N_WINDOWS] = '{9'd0, 9'd511, 9'd0,
                                                            9'd16, 9'd100, 9'd511};
    localparam logic [LINE_W-1:0] WIN_BOT [N_WINDOWS] = '{9'd511, 9'd0, 9'd0,
                                                            9'd223, 9'd300, 9'd511};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [MODE_W-1:0] mode         = '0;
    logic [ADDR_W-1:0] reg_addr     = '0;
    logic [BYTE_W-1:0] write_data   = '0;
    logic [LINE_W-1:0] current_line = '0;
    logic              vblank_level = 1'b0;
    logic              hblank_level = 1'b0;
    logic [LINE_W-1:0] gun_y        = '0;

    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [BYTE_W-1:0] read_data;
    logic              raster_a_irq;
    logic              raster_b_irq;
    logic              vblank_irq;
    logic              gun_irq;

    scanline_irq_controller DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .reg_addr     (reg_addr),
        .write_data   (write_data),
        .current_line (current_line),
        .vblank_level (vblank_level),
        .hblank_level (hblank_level),
        .gun_y        (gun_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .raster_a_irq (raster_a_irq),
        .raster_b_irq (raster_b_irq),
        .vblank_irq   (vblank_irq),
        .gun_irq      (gun_irq)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // items waiting for the driver, and results owed by the block in order
    item_t   item_backlog [$];
    result_t due_results  [$];

    // percentage of cycles in which the sender holds off / the receiver stalls
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned fault_count  = 0;
    int unsigned beats_out    = 0;
    int unsigned cycle_count  = 0;

    // ---------------------------------------------------------------------
    // predictor: shadow copy of the controller state and its window
    // ---------------------------------------------------------------------
    logic [LINE_W-1:0] win_top = VISIBLE_TOP_RESET;
    logic [LINE_W-1:0] win_bot = VISIBLE_BOTTOM_RESET;
    logic              line_two_sel = 1'b0;   // raster target: 0 line one, 1 line two
    logic              raster_off   = 1'b1;   // raster mask
    logic [BYTE_W-1:0] cmp_line     = '0;
    logic [BYTE_W-1:0] gun_line     = '0;
    logic              r1_hit       = 1'b0;
    logic              r2_hit       = 1'b0;
    logic              vbl_hit      = 1'b0;
    logic              gun_hit      = 1'b0;

    // lines the random generator aims at, tracked ahead of the predictor
    logic [BYTE_W-1:0] aim_cmp = '0;
    logic [BYTE_W-1:0] aim_gun = '0;

    function automatic logic on_screen(logic [LINE_W-1:0] line);
        return line >= win_top && line <= win_bot;
    endfunction

    // apply one item to the shadow state and return the result it causes
    function automatic result_t apply_to_controller(item_t it);
        result_t r;
        r = '0;
        case (it.mode)
            MODE_BUS_WRITE:
                case (it.reg_addr)
                    REG_CTRL:
                    begin
                        line_two_sel = it.write_data[4];
                        raster_off   = it.write_data[1];
                        if (raster_off)
                        begin
                            r1_hit = 1'b0;
                            r2_hit = 1'b0;
                        end
                    end
                    REG_COMPARE: cmp_line = it.write_data;
                    REG_ACK:     vbl_hit = 1'b0;
                    default: ;
                endcase
            MODE_BUS_READ:
                case (it.reg_addr)
                    REG_COMPARE: r.read_data = cmp_line;
                    REG_ACK:
                    begin
                        r1_hit = 1'b0;
                        r2_hit = 1'b0;
                        r.read_data = READ_ACK_VALUE;
                    end
                    REG_STATUS:
                        r.read_data = {1'b1, gun_hit, r1_hit | r2_hit, vbl_hit, 2'b00,
                                       it.vblank_level, it.hblank_level};
                    default: ;
                endcase
            MODE_TICK:
            begin
                if (on_screen({1'b0, cmp_line}) && it.current_line == {1'b0, cmp_line}
                    && !raster_off)
                begin
                    if (line_two_sel)
                        r2_hit = 1'b1;
                    else
                        r1_hit = 1'b1;
                end
                if (on_screen({1'b0, gun_line}) && it.current_line == {1'b0, gun_line})
                    gun_hit = 1'b1;
                // 10-bit sum: a bottom of 511 puts vblank start out of reach
                if ({1'b0, it.current_line} == {1'b0, win_bot} + 10'd1)
                    vbl_hit = 1'b1;
            end
            MODE_GUN_TRIG: gun_line = it.gun_y[LINE_W-1:1];
            MODE_GUN_ACK:  gun_hit = 1'b0;
            default: ;
        endcase
        r.raster_a_irq = r1_hit;
        r.raster_b_irq = r2_hit;
        r.vblank_irq   = vbl_hit;
        r.gun_irq      = gun_hit;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    task automatic queue_item(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                              logic [BYTE_W-1:0] d, logic [LINE_W-1:0] ln,
                              logic vbl, logic hbl, logic [LINE_W-1:0] gy);
        item_t it;
        it.mode         = m;
        it.reg_addr     = a;
        it.write_data   = d;
        it.current_line = ln;
        it.vblank_level = vbl;
        it.hblank_level = hbl;
        it.gun_y        = gy;
        item_backlog.push_back(it);
    endtask

    // mostly bus traffic and ticks aimed at the lines that can match, so the
    // sticky flags get set and acknowledged often; the rest is noise
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        it.reg_addr     = ADDR_W'($urandom_range(3));
        it.write_data   = BYTE_W'($urandom_range(255));
        it.current_line = LINE_W'($urandom_range(511));
        it.vblank_level = 1'($urandom_range(1));
        it.hblank_level = 1'($urandom_range(1));
        it.gun_y        = LINE_W'($urandom_range(511));
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            it.mode = MODE_BUS_WRITE;
            // keep the raster unmasked most of the time, else it never fires
            if (it.reg_addr == REG_CTRL && $urandom_range(3) != 0)
                it.write_data[1] = 1'b0;
            if (it.reg_addr == REG_COMPARE)
                aim_cmp = it.write_data;
        end
        else if (pick < 44)
            it.mode = MODE_BUS_READ;
        else if (pick < 82)
        begin
            it.mode = MODE_TICK;
            case ($urandom_range(9))
                0, 1, 2: it.current_line = {1'b0, aim_cmp};
                3, 4:    it.current_line = {1'b0, aim_gun};
                5:       it.current_line = win_bot + 9'd1;
                6:       it.current_line = win_top;
                default: ;
            endcase
        end
        else if (pick < 90)
        begin
            it.mode = MODE_GUN_TRIG;
            aim_gun = it.gun_y[LINE_W-1:1];
        end
        else if (pick < 97)
            it.mode = MODE_GUN_ACK;
        else
            it.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        return it;
    endfunction

    // sampled on the falling edge, away from the driver and monitor
    task automatic wait_drained();
        while (item_backlog.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_window_reg(logic [CFG_INDEX_W-1:0] idx, logic [LINE_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        if (idx == CFG_VISIBLE_TOP)
            win_top = val;
        else
            win_bot = val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic note_fault(string what, int unsigned want, int unsigned got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("mismatch on %s at result beat %0d: expected %0h, got %0h",
                     what, beats_out, want, got);
    endtask

    // ---------------------------------------------------------------------
    // driver: offers the next item from the backlog, predicts on acceptance
    // ---------------------------------------------------------------------
    item_t offered;
    logic  in_fire;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire = in_valid && in_ready;
            if (in_fire)
                due_results.push_back(apply_to_controller(offered));
            // a held beat stays put; a new one goes out only after the last was taken
            if ((!in_valid || in_fire) && item_backlog.size() != 0
                && $urandom_range(99) >= send_gap_pct)
            begin
                offered = item_backlog.pop_front();
                in_valid     <= 1'b1;
                mode         <= offered.mode;
                reg_addr     <= offered.reg_addr;
                write_data   <= offered.write_data;
                current_line <= offered.current_line;
                vblank_level <= offered.vblank_level;
                hblank_level <= offered.hblank_level;
                gun_y        <= offered.gun_y;
            end
            else if (in_fire)
                in_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // monitor: takes result beats and checks them against the oldest due result
    // ---------------------------------------------------------------------
    result_t got_beat;
    result_t want_beat;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_beat = {read_data, raster_a_irq, raster_b_irq, vblank_irq, gun_irq};
                if (due_results.size() == 0)
                    note_fault("unexpected beat", 0, got_beat);
                else
                begin
                    want_beat = due_results.pop_front();
                    if (got_beat.read_data !== want_beat.read_data)
                        note_fault("read_data", want_beat.read_data, got_beat.read_data);
                    if (got_beat.raster_a_irq !== want_beat.raster_a_irq)
                        note_fault("raster_a_irq", want_beat.raster_a_irq,
                                   got_beat.raster_a_irq);
                    if (got_beat.raster_b_irq !== want_beat.raster_b_irq)
                        note_fault("raster_b_irq", want_beat.raster_b_irq,
                                   got_beat.raster_b_irq);
                    if (got_beat.vblank_irq !== want_beat.vblank_irq)
                        note_fault("vblank_irq", want_beat.vblank_irq, got_beat.vblank_irq);
                    if (got_beat.gun_irq !== want_beat.gun_irq)
                        note_fault("gun_irq", want_beat.gun_irq, got_beat.gun_irq);
                end
                beats_out++;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("scanline_irq_controller regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // sequence: reset, directed checks, then windowed random blocks
    // ---------------------------------------------------------------------
    initial
    begin
        int blk;
        int chunk;
        int n;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // first third: sparse sender gaps, heavy receiver back-pressure
        send_gap_pct   = 8;
        recv_stall_pct = 72;

        // directed part, reset window (0..239)
        queue_item(MODE_BUS_WRITE, REG_CTRL, 8'h00, 9'd0, 1'b0, 1'b0, 9'd0);
        queue_item(MODE_BUS_READ,  REG_CTRL,    8'h00, 9'd0,   1'b0, 1'b0, 9'd0);
        queue_item(MODE_BUS_READ,  REG_STATUS,  8'h00, 9'd0,   1'b1, 1'b0, 9'd0);
        queue_item(MODE_BUS_READ,  REG_STATUS,  8'h00, 9'd0,   1'b0, 1'b1, 9'd0);
        // status register is read-only: write is dropped
        queue_item(MODE_BUS_WRITE, REG_STATUS,  8'hff, 9'd0,   1'b0, 1'b0, 9'd0);
        // compare line beyond the visible bottom never matches
        queue_item(MODE_BUS_WRITE, REG_COMPARE, 8'hff, 9'd0,   1'b0, 1'b0, 9'd0);
        queue_item(MODE_TICK,      REG_CTRL,    8'h00, 9'd255, 1'b0, 1'b0, 9'd0);
        queue_item(MODE_BUS_WRITE, REG_COMPARE, 8'h20, 9'd0,   1'b0, 1'b0, 9'd0);
        queue_item(MODE_TICK,      REG_CTRL,    8'h00, 9'd32,  1'b0, 1'b0, 9'd0);
        queue_item(MODE_BUS_READ,  REG_COMPARE, 8'h00, 9'd0,   1'b0, 1'b0, 9'd0);
        queue_item(MODE_BUS_READ,  REG_STATUS,  8'h00, 9'd0,   1'b1, 1'b1, 9'd0);
        // retarget to line two, unmasked
        queue_item(MODE_BUS_WRITE, REG_CTRL,    8'h10, 9'd0,   1'b0, 1'b0, 9'd0);
        queue_item(MODE_TICK,      REG_CTRL,    8'h00, 9'd32,  1'b0, 1'b0, 9'd0);
        // read of the acknowledge register drops both raster lines
        queue_item(MODE_BUS_READ,  REG_ACK,     8'h00, 9'd0,   1'b0, 1'b0, 9'd0);
        // masked raster: a matching tick sets nothing
        queue_item(MODE_BUS_WRITE, REG_CTRL,    8'h12, 9'd0,   1'b0, 1'b0, 9'd0);
        queue_item(MODE_TICK,      REG_CTRL,    8'h00, 9'd32,  1'b0, 1'b0, 9'd0);
        // gun latch at 255 is off screen
        queue_item(MODE_GUN_TRIG,  REG_CTRL,    8'h00, 9'd0,   1'b0, 1'b0, 9'd511);
        queue_item(MODE_TICK,      REG_CTRL,    8'h00, 9'd255, 1'b0, 1'b0, 9'd0);
        // odd gun y rounds down: 101 latches line 50
        queue_item(MODE_GUN_TRIG,  REG_CTRL,    8'h00, 9'd0,   1'b0, 1'b0, 9'd101);
        queue_item(MODE_TICK,      REG_CTRL,    8'h00, 9'd50,  1'b0, 1'b0, 9'd0);
        queue_item(MODE_GUN_ACK,   REG_CTRL,    8'h00, 9'd0,   1'b0, 1'b0, 9'd0);
        // line below the visible bottom starts vblank; write to ack clears it
        queue_item(MODE_TICK,      REG_CTRL,    8'h00, 9'd240, 1'b0, 1'b0, 9'd0);
        queue_item(MODE_BUS_WRITE, REG_ACK,     8'h00, 9'd0,   1'b0, 1'b0, 9'd0);
        // spare item kinds are ignored, every field at its top value
        queue_item(MODE_SPARE_HI,  REG_STATUS,  8'hff, 9'd511, 1'b1, 1'b1, 9'd511);
        queue_item(MODE_SPARE_LO,  REG_STATUS,  8'hff, 9'd511, 1'b1, 1'b1, 9'd511);
        wait_drained();

        for (blk = 0; blk < N_WINDOWS; blk++)
        begin
            // second third swaps the pressure, last third runs flat out
            if (blk == 2)
            begin
                send_gap_pct   = 72;
                recv_stall_pct = 8;
            end
            else if (blk == 4)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            // block is idle here; give the pipeline its latency before reconfiguring
            repeat (3) @(negedge clk);
            write_window_reg(CFG_VISIBLE_TOP, WIN_TOP[blk]);
            write_window_reg(CFG_VISIBLE_BOTTOM, WIN_BOT[blk]);
            @(negedge clk);
            // each chunk drains completely before the next: the sender sits out
            // until every owed result has come back
            for (chunk = 0; chunk < CHUNKS; chunk++)
            begin
                aim_cmp = cmp_line;
                aim_gun = gun_line;
                for (n = 0; n < CHUNK_ITEMS; n++)
                    item_backlog.push_back(random_item());
                wait_drained();
            end
        end

        // allow for late stray beats after the last owed one
        repeat (8) @(negedge clk);
        if (due_results.size() != 0)
            note_fault("results still owed", 0, due_results.size());

        if (fault_count == 0)
            $display("scanline_irq_controller regression: pass");
        else
            $display("scanline_irq_controller regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sic_pkg.sv
hdl/sic_in_stage.sv
hdl/sic_core.sv
hdl/sic_out_stage.sv
hdl/scanline_irq_controller.sv
bench/scanline_irq_controller_tb.sv
